/* hw/rtl/gnv_pkg.sv */
package gnv_pkg;

  // offsets inside the packet never pass 511 (largest is inner l4 start + 20)
  localparam int unsigned OFS_W = 9;
  typedef logic [OFS_W-1:0] ofs_t;

  localparam logic [15:0] TUNNEL_PORT_DEFAULT = 16'd6081;
  localparam logic [15:0] TYPE_IPV4           = 16'h0800;
  localparam logic [15:0] TYPE_TEB            = 16'h6558;
  localparam logic [7:0]  PROTO_ICMP          = 8'd1;
  localparam logic [7:0]  PROTO_TCP           = 8'd6;
  localparam logic [7:0]  PROTO_UDP           = 8'd17;

  localparam ofs_t ETH_HDR_LEN  = ofs_t'(14);
  localparam ofs_t IP_HDR_MIN   = ofs_t'(20);
  localparam ofs_t UDP_HDR_LEN  = ofs_t'(8);
  localparam ofs_t TCP_HDR_MIN  = ofs_t'(20);
  localparam ofs_t GNV_HDR_LEN  = ofs_t'(8);
  localparam ofs_t OUTER_L3_END = ofs_t'(34);
  localparam ofs_t OUTER_PROTO_POS = ofs_t'(23);

  localparam int unsigned OUT_DATA_W = 128;

  // field values as they stand after the current byte, plus header offsets
  typedef struct packed {
    logic [15:0] ethertype;
    logic [7:0]  outer_proto;
    logic [15:0] outer_dport;
    logic [15:0] payload_type;
    logic [7:0]  inner_proto;
    logic [31:0] inner_src;
    logic [31:0] inner_dst;
    logic [15:0] l4_sport;
    logic [15:0] l4_dport;
    ofs_t        ofs_udp;
    ofs_t        ofs_gnv;
    ofs_t        ofs_eth;
    ofs_t        ofs_ip;
    ofs_t        ofs_l4;
  } capt_t;

endpackage

/* hw/rtl/geneve_tunnel_header_parser_core.sv */
// channel  | dir | handshake                    | payload
// ---------+-----+------------------------------+-------------------------------------------
// s_axis   | in  | s_axis_tvalid/s_axis_tready  | tdata[7:0] data_byte, tlast last_byte
// m_axis   | out | m_axis_tvalid/m_axis_tready  | tdata 128b verdict..dst_port (see port)
// cfg      | in  | cfg_we_i (no wait)           | cfg_wdata_i tunnel_udp_port
//
// one byte per cycle while s_axis_tready is high; the verdict for a packet is loaded
// into the result register when its last byte is taken, nothing is sent for other bytes
// field capture and the decision are one pass of logic off the byte counter and the
// header offset adders, so the byte rate is one per clock while s_axis_tready is high
// reset clears the byte counter, every captured field and the result register;
// tunnel_udp_port returns to 6081
// s_axis_tready drops only while a result sits in the output register and
// m_axis_tready is low
module geneve_tunnel_header_parser_core #(
  parameter int unsigned LENGTH_BITS = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [7:0]                      s_axis_tdata,   // [7:0] data_byte
  input  logic                            s_axis_tlast,   // last_byte
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // [0] verdict, [1] event_valid, [9:2] inner_protocol, [25:10] frame_length,
  // [57:26] src_address, [89:58] dst_address, [105:90] src_port,
  // [121:106] dst_port, [127:122] zero
  output logic [gnv_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
  input  logic                            cfg_we_i,
  input  logic [15:0]                     cfg_wdata_i
);
  import gnv_pkg::*;

  localparam int unsigned LenW = (LENGTH_BITS > 16) ? LENGTH_BITS : 16;

  logic                   accept;
  capt_t                  capt;
  logic [LENGTH_BITS-1:0] count;
  logic [LenW-1:0]        count_w;
  logic [15:0]            frame_len;
  logic [15:0]            tunnel_port_q;
  logic                   out_valid_q, out_valid_d;
  logic [OUT_DATA_W-1:0]  out_data_q, out_data_d;
  logic                   n_hi;
  ofs_t                   n_lo;
  logic                   is_tunnel, verdict, event_ok, ports_ok;
  logic [7:0]             proto;

  // count at least as large as the offset
  function automatic logic ge(logic hi, ofs_t lo, ofs_t x);
    return hi || (lo >= x);
  endfunction

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  gnv_capture #(
    .LENGTH_BITS(LENGTH_BITS)
  ) u_capture (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .accept_i(accept),
    .byte_i  (s_axis_tdata),
    .last_i  (s_axis_tlast),
    .capt_o  (capt),
    .count_o (count)
  );

  // tunnel port register, written whenever the enable is high
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tunnel_port_q <= TUNNEL_PORT_DEFAULT;
    end else if (cfg_we_i) begin
      tunnel_port_q <= cfg_wdata_i;
    end
  end

  assign n_hi = |count[LENGTH_BITS-1:OFS_W];
  assign n_lo = count[OFS_W-1:0];

  // saturate the byte count into the 16 bit frame length field
  assign count_w   = LenW'(count);
  assign frame_len = (count_w > LenW'(16'hFFFF)) ? 16'hFFFF : count_w[15:0];

  // verdict tree on the last byte, checks in the order of the header stack
  always_comb begin
    verdict  = 1'b0;
    event_ok = 1'b0;
    proto    = '0;
    is_tunnel = ge(n_hi, n_lo, ETH_HDR_LEN) && (capt.ethertype == TYPE_IPV4) &&
                ge(n_hi, n_lo, OUTER_L3_END) && (capt.outer_proto == PROTO_UDP) &&
                ge(n_hi, n_lo, capt.ofs_udp + UDP_HDR_LEN) &&
                (capt.outer_dport == tunnel_port_q);
    if (is_tunnel) begin
      if (!ge(n_hi, n_lo, capt.ofs_gnv + GNV_HDR_LEN)) begin
        // geneve header cut short
        verdict = 1'b1;
      end else if (capt.payload_type == TYPE_TEB) begin
        if (!ge(n_hi, n_lo, capt.ofs_eth + ETH_HDR_LEN) ||
            !ge(n_hi, n_lo, capt.ofs_ip + IP_HDR_MIN)) begin
          // inner ethernet or ipv4 header cut short
          verdict = 1'b1;
        end else begin
          event_ok = 1'b1;
          unique case (capt.inner_proto)
            PROTO_TCP: begin
              proto = PROTO_TCP;
              if (!ge(n_hi, n_lo, capt.ofs_l4 + TCP_HDR_MIN)) event_ok = 1'b0;
            end
            PROTO_UDP: begin
              proto = PROTO_UDP;
              if (!ge(n_hi, n_lo, capt.ofs_l4 + UDP_HDR_LEN)) event_ok = 1'b0;
            end
            PROTO_ICMP: begin
              proto = PROTO_ICMP;
            end
            default: begin
              proto = '0;
            end
          endcase
        end
      end
    end
    ports_ok = (proto == PROTO_TCP) || (proto == PROTO_UDP);
  end

  // result word, all event fields zero when no event is reported
  always_comb begin
    out_data_d         = '0;
    out_data_d[0]      = verdict;
    if (event_ok) begin
      out_data_d[1]       = 1'b1;
      out_data_d[9:2]     = proto;
      out_data_d[25:10]   = frame_len;
      out_data_d[57:26]   = capt.inner_src;
      out_data_d[89:58]   = capt.inner_dst;
      out_data_d[105:90]  = ports_ok ? capt.l4_sport : 16'h0000;
      out_data_d[121:106] = ports_ok ? capt.l4_dport : 16'h0000;
    end
  end

  // output register: loads on the last byte, frees when the transaction completes
  always_comb begin
    out_valid_d = out_valid_q;
    if (accept && s_axis_tlast) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_data_q <= '0;
    end else if (accept && s_axis_tlast) begin
      out_data_q <= out_data_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

/* hw/rtl/gnv_capture.sv */
module gnv_capture #(
  parameter int unsigned LENGTH_BITS = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   accept_i,
  input  logic [7:0]             byte_i,
  input  logic                   last_i,
  output gnv_pkg::capt_t         capt_o,
  output logic [LENGTH_BITS-1:0] count_o
);
  import gnv_pkg::*;

  logic [LENGTH_BITS-1:0] pos_q, pos_d, count;
  logic [15:0] eth_q, eth_d;
  logic [3:0]  ohw_q, ohw_d;
  logic [7:0]  oproto_q, oproto_d;
  logic [15:0] odport_q, odport_d;
  logic [5:0]  opt_q, opt_d;
  logic [15:0] ptype_q, ptype_d;
  logic [3:0]  ihw_q, ihw_d;
  logic [7:0]  iproto_q, iproto_d;
  logic [31:0] isrc_q, isrc_d;
  logic [31:0] idst_q, idst_d;
  logic [15:0] sport_q, sport_d;
  logic [15:0] dport_q, dport_d;
  logic        p_hi;
  ofs_t        p_lo, ofs_u, ofs_g, ofs_e, ofs_i, ofs_l;

  function automatic logic at_pos(logic hi, ofs_t lo, ofs_t s);
    return !hi && (lo == s);
  endfunction

  function automatic logic in_span(logic hi, ofs_t lo, ofs_t s, logic [2:0] len);
    logic [OFS_W:0] lo_w, s_w;
    lo_w = {1'b0, lo};
    s_w  = {1'b0, s};
    return !hi && (lo_w >= s_w) && (lo_w < s_w + (OFS_W+1)'(len));
  endfunction

  // positions above the largest offset never match
  assign p_hi = |pos_q[LENGTH_BITS-1:OFS_W];
  assign p_lo = pos_q[OFS_W-1:0];

  // each offset follows the field values updated by this byte
  always_comb begin
    eth_d    = in_span(p_hi, p_lo, ofs_t'(12), 3'd2) ? {eth_q[7:0], byte_i} : eth_q;
    ohw_d    = at_pos(p_hi, p_lo, ETH_HDR_LEN) ? byte_i[3:0] : ohw_q;
    oproto_d = at_pos(p_hi, p_lo, OUTER_PROTO_POS) ? byte_i : oproto_q;
    ofs_u    = ETH_HDR_LEN + ofs_t'({ohw_d, 2'b00});
    odport_d = in_span(p_hi, p_lo, ofs_u + ofs_t'(2), 3'd2) ?
               {odport_q[7:0], byte_i} : odport_q;
    ofs_g    = ofs_u + UDP_HDR_LEN;
    opt_d    = at_pos(p_hi, p_lo, ofs_g) ? byte_i[5:0] : opt_q;
    ptype_d  = in_span(p_hi, p_lo, ofs_g + ofs_t'(2), 3'd2) ?
               {ptype_q[7:0], byte_i} : ptype_q;
    ofs_e    = ofs_g + GNV_HDR_LEN + ofs_t'({opt_d, 2'b00});
    ofs_i    = ofs_e + ETH_HDR_LEN;
    ihw_d    = at_pos(p_hi, p_lo, ofs_i) ? byte_i[3:0] : ihw_q;
    iproto_d = at_pos(p_hi, p_lo, ofs_i + ofs_t'(9)) ? byte_i : iproto_q;
    isrc_d   = in_span(p_hi, p_lo, ofs_i + ofs_t'(12), 3'd4) ?
               {isrc_q[23:0], byte_i} : isrc_q;
    idst_d   = in_span(p_hi, p_lo, ofs_i + ofs_t'(16), 3'd4) ?
               {idst_q[23:0], byte_i} : idst_q;
    ofs_l    = ofs_i + ofs_t'({ihw_d, 2'b00});
    sport_d  = in_span(p_hi, p_lo, ofs_l, 3'd2) ? {sport_q[7:0], byte_i} : sport_q;
    dport_d  = in_span(p_hi, p_lo, ofs_l + ofs_t'(2), 3'd2) ?
               {dport_q[7:0], byte_i} : dport_q;
    count    = (&pos_q) ? pos_q : pos_q + LENGTH_BITS'(1);
    pos_d    = count;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      eth_q    <= '0;
      ohw_q    <= '0;
      oproto_q <= '0;
      odport_q <= '0;
      opt_q    <= '0;
      ptype_q  <= '0;
      ihw_q    <= '0;
      iproto_q <= '0;
      isrc_q   <= '0;
      idst_q   <= '0;
      sport_q  <= '0;
      dport_q  <= '0;
    end else if (accept_i) begin
      if (last_i) begin
        pos_q    <= '0;
        eth_q    <= '0;
        ohw_q    <= '0;
        oproto_q <= '0;
        odport_q <= '0;
        opt_q    <= '0;
        ptype_q  <= '0;
        ihw_q    <= '0;
        iproto_q <= '0;
        isrc_q   <= '0;
        idst_q   <= '0;
        sport_q  <= '0;
        dport_q  <= '0;
      end else begin
        pos_q    <= pos_d;
        eth_q    <= eth_d;
        ohw_q    <= ohw_d;
        oproto_q <= oproto_d;
        odport_q <= odport_d;
        opt_q    <= opt_d;
        ptype_q  <= ptype_d;
        ihw_q    <= ihw_d;
        iproto_q <= iproto_d;
        isrc_q   <= isrc_d;
        idst_q   <= idst_d;
        sport_q  <= sport_d;
        dport_q  <= dport_d;
      end
    end
  end

  always_comb begin
    capt_o.ethertype    = eth_d;
    capt_o.outer_proto  = oproto_d;
    capt_o.outer_dport  = odport_d;
    capt_o.payload_type = ptype_d;
    capt_o.inner_proto  = iproto_d;
    capt_o.inner_src    = isrc_d;
    capt_o.inner_dst    = idst_d;
    capt_o.l4_sport     = sport_d;
    capt_o.l4_dport     = dport_d;
    capt_o.ofs_udp      = ofs_u;
    capt_o.ofs_gnv      = ofs_g;
    capt_o.ofs_eth      = ofs_e;
    capt_o.ofs_ip       = ofs_i;
    capt_o.ofs_l4       = ofs_l;
  end

  assign count_o = count;

endmodule
